// ===== design/lfcl_pkg.sv =====
`timescale 1ns / 1ps

package lfcl_pkg;

  localparam int unsigned COL_W      = 8;
  localparam int unsigned MA_W       = 14;
  localparam int unsigned LIMIT_W    = 27;
  localparam int unsigned CFG_DATA_W = 27;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned SUM_W      = 41;
  localparam int unsigned CUR_OUT_W  = 26;
  localparam int unsigned FCNT_W     = 32;
  localparam int unsigned LVLPROD_W  = 24;
  localparam int unsigned CLPROD_W   = 16;
  localparam int unsigned PROD_W     = CLPROD_W + MA_W;

  localparam int unsigned FULL       = 255;
  localparam int unsigned LEVEL_DIV  = FULL * FULL;
  localparam int unsigned LEVEL_GAP  = 65536 - LEVEL_DIV;
  localparam int unsigned RESCALE_NUM = 254;

  localparam logic [COL_W-1:0]     FULL_LEVEL = COL_W'(FULL);
  localparam logic [CUR_OUT_W-1:0] CUR_MAX    = '1;
  localparam logic [SUM_W-1:0]     SUM_MAX    = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GLOBAL,
    CFG_PANEL,
    CFG_RED,
    CFG_GREEN,
    CFG_BLUE,
    CFG_BASE,
    CFG_LIMIT
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MUL_RED,
    MUL_GREEN,
    MUL_BLUE
  } mul_sel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LVL2,
    S_LVL3,
    S_PROD,
    S_MR,
    S_MG,
    S_MB,
    S_MADD,
    S_DIV1,
    S_DIV1W,
    S_CUR,
    S_CMP,
    S_DIV2W,
    S_SCALE,
    S_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic [COL_W-1:0] red_in;
    logic [COL_W-1:0] green_in;
    logic [COL_W-1:0] blue_in;
    logic [COL_W-1:0] bright_in;
    logic             last_pixel;
  } pix_t;

  typedef struct packed {
    logic [COL_W-1:0]     red_out;
    logic [COL_W-1:0]     green_out;
    logic [COL_W-1:0]     blue_out;
    logic [COL_W-1:0]     level_out;
    logic                 frame_end;
    logic [CUR_OUT_W-1:0] frame_current;
    logic [COL_W-1:0]     rescale;
    logic                 over_limit;
    logic [CUR_OUT_W-1:0] peak_current_out;
    logic [FCNT_W-1:0]    frame_count_out;
  } res_t;

  typedef struct packed {
    logic     load_in;
    logic     lvl2;
    logic     lvl3;
    logic     prod;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     acc;
    logic     count;
    logic     div_start;
    logic     div_rescale;
    logic     base;
    logic     cur;
    logic     cmp;
    logic     scale;
    logic     load_out;
  } lfcl_cmd_t;

  typedef struct packed {
    logic last;
    logic div_done;
    logic over;
    logic out_free;
  } lfcl_sts_t;

  // floor(x / 65025) for x up to 255^3, quotient estimate from the top byte
  function automatic logic [COL_W-1:0] div_level(input logic [LVLPROD_W-1:0] x);
    logic [COL_W-1:0] q0;
    logic [17:0]      r;
    q0 = x[LVLPROD_W-1:16];
    r  = 18'(x[15:0]) + 18'(q0) * 18'(LEVEL_GAP);
    if (r >= 18'(2 * LEVEL_DIV)) begin
      return q0 + COL_W'(2);
    end else if (r >= 18'(LEVEL_DIV)) begin
      return q0 + COL_W'(1);
    end
    return q0;
  endfunction

  // floor(x / 255) for x up to 255*255
  function automatic logic [COL_W-1:0] div_full(input logic [CLPROD_W-1:0] x);
    logic [COL_W-1:0] q0;
    logic [COL_W:0]   r;
    q0 = x[CLPROD_W-1:COL_W];
    r  = (COL_W+1)'(x[COL_W-1:0]) + (COL_W+1)'(q0);
    if (r >= (COL_W+1)'(2 * FULL)) begin
      return q0 + COL_W'(2);
    end else if (r >= (COL_W+1)'(FULL)) begin
      return q0 + COL_W'(1);
    end
    return q0;
  endfunction

endpackage

// ===== design/lfcl_if.sv =====
`timescale 1ns / 1ps

interface lfcl_pix_if import lfcl_pkg::*; ();
  logic valid;
  logic ready;
  pix_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lfcl_res_if import lfcl_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/led_frame_current_limiter.sv =====
`timescale 1ns / 1ps

// LED frame current limiter. Pixels enter as words on pix_i, one at a time, and each
// gives one word on res_o with its colours and scaled brightness level. A pixel that is
// not the last of its frame is worked through before the next one is accepted: the
// three colour currents go through one shared 16x14 multiplier, one colour a cycle.
// The last pixel adds the frame-end work: the frame sum is divided by 255*255 by
// folding its high bits back in, the base current is added and the sum is compared
// with the limit, and when it is over, the rescale factor needs a bit-serial division
// (41 quotient bits). The output register lets a new pixel enter while the previous
// word still waits. Write configuration registers only while the block is idle; any
// write to a defined register index clears the peak current and a global brightness
// write reloads the active brightness.
module led_frame_current_limiter import lfcl_pkg::*; #(
  parameter int unsigned MAX_PIXELS = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  lfcl_pix_if.sink              pix_i,
  lfcl_res_if.source            res_o
);

  lfcl_cmd_t cmd;
  lfcl_sts_t sts;

  lfcl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pix_i.valid),
    .in_ready_o (pix_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lfcl_datapath #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .pix_i       (pix_i.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (res_o.data),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready)
  );

endmodule

// ===== design/lfcl_div.sv =====
`timescale 1ns / 1ps

module lfcl_div import lfcl_pkg::*; #(
  parameter int unsigned NUM_W = 41,
  parameter int unsigned DEN_W = 27
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W:0]   trial;
  logic             ge;

  // restoring division, one quotient bit a cycle
  assign trial = {rem_q, num_q[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W);
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      num_d = {num_q[NUM_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");

endmodule

// ===== design/lfcl_ctrl.sv =====
`timescale 1ns / 1ps

module lfcl_ctrl import lfcl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  lfcl_sts_t sts_i,
  output lfcl_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_RED;
    in_ready_o    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_LVL2;
        end
      end
      S_LVL2: begin
        cmd_o.lvl2 = 1'b1;
        state_d    = S_LVL3;
      end
      S_LVL3: begin
        cmd_o.lvl3 = 1'b1;
        state_d    = S_PROD;
      end
      S_PROD: begin
        cmd_o.prod = 1'b1;
        state_d    = S_MR;
      end
      S_MR: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_RED;
        state_d       = S_MG;
      end
      S_MG: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_GREEN;
        cmd_o.acc     = 1'b1;
        state_d       = S_MB;
      end
      S_MB: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_BLUE;
        cmd_o.acc     = 1'b1;
        state_d       = S_MADD;
      end
      S_MADD: begin
        cmd_o.acc   = 1'b1;
        cmd_o.count = 1'b1;
        state_d     = sts_i.last ? S_DIV1 : S_OUT;
      end
      S_DIV1: begin
        cmd_o.div_start = 1'b1;
        cmd_o.base      = 1'b1;
        state_d         = S_DIV1W;
      end
      S_DIV1W: begin
        if (sts_i.div_done) begin
          state_d = S_CUR;
        end
      end
      S_CUR: begin
        cmd_o.cur = 1'b1;
        state_d   = S_CMP;
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        if (sts_i.over) begin
          cmd_o.div_start   = 1'b1;
          cmd_o.div_rescale = 1'b1;
          state_d           = S_DIV2W;
        end else begin
          state_d = S_OUT;
        end
      end
      S_DIV2W: begin
        cmd_o.div_rescale = 1'b1;
        if (sts_i.div_done) begin
          state_d = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == S_DIV1W || state_q == S_DIV2W))
    else $error("division finished outside a wait state");

endmodule

// ===== design/lfcl_datapath.sv =====
`timescale 1ns / 1ps

module lfcl_datapath import lfcl_pkg::*; #(
  parameter int unsigned MAX_PIXELS = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  pix_t                  pix_i,
  input  lfcl_cmd_t             cmd_i,
  output lfcl_sts_t             sts_o,
  output res_t                  res_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i
);

  localparam int unsigned CNT_W  = $clog2(MAX_PIXELS + 1);
  localparam int unsigned BASE_W = MA_W + CNT_W;
  localparam int unsigned CUR_W  = ((BASE_W > CUR_OUT_W) ? BASE_W : CUR_OUT_W) + 1;
  localparam int unsigned FOLD_STEPS = 5;
  localparam int unsigned FSTEP_W    = $clog2(FOLD_STEPS + 1);
  localparam int unsigned HI_W       = SUM_W - CLPROD_W;

  // configuration
  logic [COL_W-1:0]   ab_q, pb_q;
  logic [MA_W-1:0]    rma_q, gma_q, bma_q, base_q;
  logic [LIMIT_W-1:0] limit_q;
  logic               cfg_hit;

  // pixel path
  pix_t                pix_q;
  logic [CLPROD_W-1:0] p1_q;
  logic [LVLPROD_W-1:0] p2_q;
  logic [COL_W-1:0]    level_q;
  logic [CLPROD_W-1:0] rl_q, gl_q, bl_q;
  logic [CLPROD_W-1:0] mul_a;
  logic [MA_W-1:0]     mul_b;
  logic [PROD_W-1:0]   prod_q;

  // frame state
  logic [SUM_W-1:0]     sum_q;
  logic [SUM_W:0]       sum_ext;
  logic [CNT_W-1:0]     count_q;
  logic [BASE_W-1:0]    basep_q;
  logic [CUR_W-1:0]     cur_q;
  logic [CUR_OUT_W-1:0] cur_sat;
  logic                 over_now;
  logic                 over_q;
  logic [COL_W-1:0]     rescale_q;
  logic [CUR_OUT_W-1:0] peak_q;
  logic [FCNT_W-1:0]    fcount_q;

  // frame sum / 65025 by folding the high part back in
  logic [SUM_W-1:0]     frem_q;
  logic [CUR_OUT_W-1:0] fquo_q;
  logic [FSTEP_W-1:0]   fold_cnt_q;
  logic                 fold_done_q;
  logic                 fold_start;
  logic [HI_W-1:0]      fold_hi;
  logic [CUR_OUT_W-1:0] frame_quo;

  // divider
  logic [SUM_W-1:0] div_num;
  logic [CUR_W-1:0] div_den;
  logic [SUM_W-1:0] div_quo;
  logic             div_done;
  logic             div_go;

  // result word
  res_t res_q, res_d;
  logic out_valid_q;

  assign cfg_hit = cfg_we_i && (cfg_idx_i <= CFG_LIMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pb_q    <= FULL_LEVEL;
      rma_q   <= '0;
      gma_q   <= '0;
      bma_q   <= '0;
      base_q  <= '0;
      limit_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PANEL: pb_q    <= cfg_data_i[COL_W-1:0];
        CFG_RED:   rma_q   <= cfg_data_i[MA_W-1:0];
        CFG_GREEN: gma_q   <= cfg_data_i[MA_W-1:0];
        CFG_BLUE:  bma_q   <= cfg_data_i[MA_W-1:0];
        CFG_BASE:  base_q  <= cfg_data_i[MA_W-1:0];
        CFG_LIMIT: limit_q <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // active brightness: frame rescale, or reload from a global brightness write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ab_q <= FULL_LEVEL;
    end else if (cmd_i.scale) begin
      ab_q <= div_full(CLPROD_W'(ab_q) * CLPROD_W'(div_quo[COL_W-1:0]));
    end else if (cfg_we_i && (cfg_idx_i == CFG_GLOBAL)) begin
      ab_q <= cfg_data_i[COL_W-1:0];
    end
  end

  always_comb begin
    unique case (cmd_i.mul_sel)
      MUL_GREEN: begin
        mul_a = gl_q;
        mul_b = gma_q;
      end
      MUL_BLUE: begin
        mul_a = bl_q;
        mul_b = bma_q;
      end
      default: begin
        mul_a = rl_q;
        mul_b = rma_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      pix_q <= pix_i;
      p1_q  <= CLPROD_W'(pix_i.bright_in) * CLPROD_W'(ab_q);
    end
    if (cmd_i.lvl2) begin
      p2_q <= LVLPROD_W'(p1_q) * LVLPROD_W'(pb_q);
    end
    if (cmd_i.lvl3) begin
      level_q <= div_level(p2_q);
    end
    if (cmd_i.prod) begin
      rl_q <= CLPROD_W'(pix_q.red_in) * CLPROD_W'(level_q);
      gl_q <= CLPROD_W'(pix_q.green_in) * CLPROD_W'(level_q);
      bl_q <= CLPROD_W'(pix_q.blue_in) * CLPROD_W'(level_q);
    end
    if (cmd_i.mul_en) begin
      prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (cmd_i.base) begin
      basep_q <= BASE_W'(base_q) * BASE_W'(count_q);
    end
    if (cmd_i.cur) begin
      cur_q <= CUR_W'(frame_quo) + CUR_W'(basep_q);
    end
  end

  // saturating colour current sum
  assign sum_ext = {1'b0, sum_q} + (SUM_W+1)'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
    end else if (cmd_i.load_out && pix_q.last_pixel) begin
      sum_q   <= '0;
      count_q <= '0;
    end else begin
      if (cmd_i.acc) begin
        sum_q <= sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
      end
      if (cmd_i.count && (count_q != CNT_W'(MAX_PIXELS))) begin
        count_q <= count_q + CNT_W'(1);
      end
    end
  end

  // x = q * 65025 + r, the top bits of r go back in as hi * 511
  assign fold_start = cmd_i.div_start && !cmd_i.div_rescale;
  assign fold_hi    = frem_q[SUM_W-1:CLPROD_W];
  assign frame_quo  = fquo_q + CUR_OUT_W'(frem_q >= SUM_W'(LEVEL_DIV));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_cnt_q  <= '0;
      fold_done_q <= 1'b0;
    end else begin
      fold_done_q <= !fold_start && (fold_cnt_q == FSTEP_W'(1));
      if (fold_start) begin
        fold_cnt_q <= FSTEP_W'(FOLD_STEPS);
      end else if (fold_cnt_q != '0) begin
        fold_cnt_q <= fold_cnt_q - FSTEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fold_start) begin
      frem_q <= sum_q;
      fquo_q <= '0;
    end else if (fold_cnt_q != '0) begin
      frem_q <= SUM_W'(frem_q[CLPROD_W-1:0]) + SUM_W'(fold_hi) * SUM_W'(LEVEL_GAP);
      fquo_q <= fquo_q + CUR_OUT_W'(fold_hi);
    end
  end

  assign over_now = (limit_q != '0) && (cur_q > CUR_W'(limit_q));
  assign cur_sat  = (cur_q > CUR_W'(CUR_MAX)) ? CUR_MAX : cur_q[CUR_OUT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q    <= '0;
      fcount_q  <= '0;
      over_q    <= 1'b0;
      rescale_q <= FULL_LEVEL;
    end else begin
      if (cmd_i.cmp) begin
        over_q <= over_now;
        if (!over_now) begin
          rescale_q <= FULL_LEVEL;
          fcount_q  <= fcount_q + FCNT_W'(1);
        end
      end
      if (cmd_i.scale) begin
        rescale_q <= div_quo[COL_W-1:0];
      end
      if (cmd_i.cmp && !over_now) begin
        if (cur_sat > peak_q) begin
          peak_q <= cur_sat;
        end
      end else if (cfg_hit) begin
        peak_q <= '0;
      end
    end
  end

  // 254 * limit as shifts
  assign div_num = SUM_W'({limit_q, 8'd0}) - SUM_W'({limit_q, 1'b0});
  assign div_den = cur_q;
  assign div_go  = cmd_i.div_start && cmd_i.div_rescale;

  lfcl_div #(
    .NUM_W (SUM_W),
    .DEN_W (CUR_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    res_d                  = '0;
    res_d.red_out          = pix_q.red_in;
    res_d.green_out        = pix_q.green_in;
    res_d.blue_out         = pix_q.blue_in;
    res_d.level_out        = level_q;
    res_d.frame_end        = pix_q.last_pixel;
    if (pix_q.last_pixel) begin
      res_d.frame_current    = cur_sat;
      res_d.rescale          = rescale_q;
      res_d.over_limit       = over_q;
      res_d.peak_current_out = peak_q;
      res_d.frame_count_out  = fcount_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign res_o       = res_q;
  assign out_valid_o = out_valid_q;

  assign sts_o.last     = pix_q.last_pixel;
  assign sts_o.div_done = div_done || fold_done_q;
  assign sts_o.over     = over_now;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  a_scale_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scale |=> ab_q <= $past(ab_q))
    else $error("active brightness grew on rescale");

  a_rescale_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scale |=> rescale_q < FULL_LEVEL)
    else $error("rescale factor out of range");

  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out && pix_q.last_pixel |=> sum_q == '0 && count_q == '0)
    else $error("frame sum not cleared after last pixel");

endmodule
